// ----- rtl/core/mltlb_pkg.sv -----
`default_nettype none

package mltlb_pkg;

	// Field widths of the stream items
	localparam int PAGE_W  = 64;
	localparam int STAMP_W = 64;
	localparam int CPU_W   = 2;
	localparam int WAY_O_W = 2;
	localparam int COUNT_W = 3;

	// Configuration register widths and reset values
	localparam int ACPU_W = 3;
	localparam int SETB_W = 4;
	localparam int AWAY_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [ACPU_W-1:0] ACPU_RST = 3'd4;
	localparam logic [SETB_W-1:0] SETB_RST = 4'd9;
	localparam logic [AWAY_W-1:0] AWAY_RST = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CPUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WAYS = 2'd2;

	// Operation codes
	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_INVAL  = 1'b1;

	// Status codes
	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_BAD_CPU = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/mltlb_match.sv -----
`default_nettype none

// Compare all active ways of one set row; report the lowest hit way and
// the lowest invalid way.
module mltlb_match #(
	parameter int WAYS = 4
) (
	input  wire logic [WAYS-1:0]                        valid,
	input  wire logic [WAYS-1:0][mltlb_pkg::PAGE_W-1:0] pages,
	input  wire logic [mltlb_pkg::PAGE_W-1:0]           page,
	input  wire logic [mltlb_pkg::AWAY_W-1:0]           ways_eff,
	output logic                                        hit,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  hit_way,
	output logic                                        free,
	output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]  free_way
);

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	always_comb begin
		hit      = 1'b0;
		hit_way  = '0;
		free     = 1'b0;
		free_way = '0;
		// walk down so the lowest way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (w < int'(ways_eff)) begin
				if (valid[w] && (pages[w] == page)) begin
					hit     = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!valid[w]) begin
					free     = 1'b1;
					free_way = WAY_W'(w);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/multi_cpu_lru_tlb_with_shootdown_unit.sv -----
// Per-CPU set-associative TLB with timestamp LRU replacement and shootdown.
// Input stream (s_*): one item is an access (tuser = 0) on one CPU or an
// invalidate (tuser = 1) of a page in every active CPU. Output stream (m_*)
// returns exactly one result item per input item, in order.
// Configuration channel (cfg_*): always ready; write only while idle.
// All CPU TLBs live in one synchronous row memory, one row per CPU and set,
// holding every way's valid bit, page and stamp; each item does
// read-modify-write passes over it, one item in flight at a time.
// Work per item, from accept to the next accept:
//   access hit or fill of a free way: one row read, compare and write
//   access miss with all active ways valid: one stamp compare per cycle
//     in the LRU victim scan over the active ways, then the write
//   invalidate: one row read/write per effective CPU
//   CPU out of range, or invalidate with no active CPU: no row access
// Reset: a clearing pass writes every row to zero, CPU_COUNT * SETS rows
// (2048 at the defaults), with s_tready low; config writes are taken.
// When the receiver stalls, the result register holds; the block finishes
// the next item and waits with it until the output register frees.
`default_nettype none

module multi_cpu_lru_tlb_with_shootdown_unit #(
	parameter int CPU_COUNT = 4,
	parameter int SETS      = 512,
	parameter int WAYS      = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // [1:0] cpu, [65:2] page, [71:66] zero
	input  wire logic [0:0]  s_tuser,   // [0] operation
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [0] hit, [2:1] way, [5:3] cleared_count, [7:6] zero
	output logic [0:0]       m_tuser,   // [0] status
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [mltlb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [mltlb_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int ROWS         = CPU_COUNT * SETS;
	localparam int ROW_AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SET_W        = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SET_BITS_MAX = $clog2(SETS + 1) - 1;
	localparam int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1;

	// one memory row: all ways of one set of one CPU
	typedef struct packed {
		logic [WAYS-1:0]                         valid;
		logic [WAYS-1:0][mltlb_pkg::STAMP_W-1:0] stamp;
		logic [WAYS-1:0][mltlb_pkg::PAGE_W-1:0]  page;
	} row_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC_LOOK,
		ST_ACC_SCAN,
		ST_INV_LOOK,
		ST_FIN
	} state_t;

	// configuration
	logic [mltlb_pkg::ACPU_W-1:0] act_cpus_q;
	logic [mltlb_pkg::SETB_W-1:0] set_bits_q;
	logic [mltlb_pkg::AWAY_W-1:0] act_ways_q;

	logic [mltlb_pkg::ACPU_W-1:0] cpus_eff;
	logic [mltlb_pkg::AWAY_W-1:0] ways_eff;
	logic [mltlb_pkg::SETB_W-1:0] set_bits_eff;
	logic [SET_W:0]               set_ones;
	logic [SET_W-1:0]             set_mask;

	// input decode
	logic                           in_op;
	logic [mltlb_pkg::CPU_W-1:0]    in_cpu;
	logic [mltlb_pkg::PAGE_W-1:0]   in_page;
	logic [SET_W-1:0]               in_set;
	logic                           accept;
	logic                           out_free;

	// control and result registers
	state_t                         state_q;
	logic [ROW_AW-1:0]              clr_q;
	logic [mltlb_pkg::ACPU_W-1:0]   cpu_q;
	logic [mltlb_pkg::COUNT_W-1:0]  cnt_q;
	logic [WAY_W-1:0]               victim_q;
	logic [WAY_W-1:0]               scan_q;
	logic [mltlb_pkg::STAMP_W-1:0]  use_clock_q;
	logic                           res_status_q;
	logic                           res_hit_q;
	logic [WAY_W-1:0]               res_way_q;
	logic [mltlb_pkg::COUNT_W-1:0]  res_count_q;
	logic                           m_tvalid_q;
	logic [7:0]                     m_tdata_q;
	logic                           m_tuser_q;

	// payload registers
	logic [mltlb_pkg::PAGE_W-1:0]   page_q;
	logic [SET_W-1:0]               set_q;

	// memory
	row_t                           row_mem_q [ROWS];
	row_t                           rd_row_q;
	row_t                           wr_row;
	logic [ROW_AW-1:0]              wr_addr;
	logic [ROW_AW-1:0]              rd_addr;
	logic                           we;
	logic                           re;

	// way logic
	logic                           hit_any;
	logic [WAY_W-1:0]               hit_way;
	logic                           free_any;
	logic [WAY_W-1:0]               free_way;
	logic                           acc_we;
	logic [WAY_W-1:0]               acc_way;
	logic [WAY_W-1:0]               v_next;
	logic                           last_scan;
	logic                           inv_more;
	logic [mltlb_pkg::ACPU_W-1:0]   cpu_next;

	function automatic logic [ROW_AW-1:0] row_of(
		input logic [mltlb_pkg::ACPU_W-1:0] c,
		input logic [SET_W-1:0]             s
	);
		row_of = ROW_AW'(int'(c) * SETS + int'(s));
	endfunction

	// effective configuration
	always_comb begin
		cpus_eff = (int'(act_cpus_q) > CPU_COUNT) ? mltlb_pkg::ACPU_W'(CPU_COUNT) : act_cpus_q;
		if (act_ways_q == '0) begin
			ways_eff = mltlb_pkg::AWAY_W'(1);
		end else if (int'(act_ways_q) > WAYS) begin
			ways_eff = mltlb_pkg::AWAY_W'(WAYS);
		end else begin
			ways_eff = act_ways_q;
		end
		set_bits_eff = (int'(set_bits_q) > SET_BITS_MAX) ?
			mltlb_pkg::SETB_W'(SET_BITS_MAX) : set_bits_q;
		set_ones = ((SET_W + 1)'(1) << set_bits_eff) - (SET_W + 1)'(1);
		set_mask = set_ones[SET_W-1:0];
	end

	assign in_op    = s_tuser[0];
	assign in_cpu   = s_tdata[1:0];
	assign in_page  = s_tdata[65:2];
	assign in_set   = in_page[SET_W-1:0] & set_mask;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_cpus_q <= mltlb_pkg::ACPU_RST;
			set_bits_q <= mltlb_pkg::SETB_RST;
			act_ways_q <= mltlb_pkg::AWAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mltlb_pkg::CFG_ACTIVE_CPUS: act_cpus_q <= cfg_data[mltlb_pkg::ACPU_W-1:0];
				mltlb_pkg::CFG_SET_BITS:    set_bits_q <= cfg_data[mltlb_pkg::SETB_W-1:0];
				mltlb_pkg::CFG_ACTIVE_WAYS: act_ways_q <= cfg_data[mltlb_pkg::AWAY_W-1:0];
				default: ;
			endcase
		end
	end

	mltlb_match #(
		.WAYS(WAYS)
	) u_match (
		.valid    (rd_row_q.valid),
		.pages    (rd_row_q.page),
		.page     (page_q),
		.ways_eff (ways_eff),
		.hit      (hit_any),
		.hit_way  (hit_way),
		.free     (free_any),
		.free_way (free_way)
	);

	// first look: a hit, a free way or a single active way settles it at once
	assign acc_we  = hit_any || free_any || (ways_eff == mltlb_pkg::AWAY_W'(1));
	assign acc_way = hit_any ? hit_way : (free_any ? free_way : '0);

	// LRU scan: one stamp compare per cycle, strict less keeps the lower way on a tie
	assign v_next    = (rd_row_q.stamp[scan_q] < rd_row_q.stamp[victim_q]) ? scan_q : victim_q;
	assign last_scan = (int'(scan_q) == int'(ways_eff) - 1);

	assign cpu_next = cpu_q + mltlb_pkg::ACPU_W'(1);
	assign inv_more = (cpu_next < cpus_eff);

	// memory port control
	always_comb begin
		we      = 1'b0;
		re      = 1'b0;
		wr_addr = row_of(cpu_q, set_q);
		wr_row  = rd_row_q;
		rd_addr = row_of((in_op == mltlb_pkg::OP_INVAL) ? '0 : {1'b0, in_cpu}, in_set);
		case (state_q)
			ST_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_q;
				wr_row  = '0;
			end
			ST_IDLE: begin
				if (in_op == mltlb_pkg::OP_INVAL) begin
					re = accept && (cpus_eff != '0);
				end else begin
					re = accept && ({1'b0, in_cpu} < cpus_eff);
				end
			end
			ST_ACC_LOOK: begin
				we = acc_we;
				wr_row.valid[acc_way] = 1'b1;
				wr_row.page[acc_way]  = page_q;
				wr_row.stamp[acc_way] = use_clock_q;
			end
			ST_ACC_SCAN: begin
				we = last_scan;
				wr_row.valid[v_next] = 1'b1;
				wr_row.page[v_next]  = page_q;
				wr_row.stamp[v_next] = use_clock_q;
			end
			ST_INV_LOOK: begin
				// write back this CPU's row, fetch the next CPU's row
				we = hit_any;
				wr_row.valid[hit_way] = 1'b0;
				re = inv_more;
				rd_addr = row_of(cpu_next, set_q);
			end
			default: ;
		endcase
	end

	// row memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			row_mem_q[wr_addr] <= wr_row;
		end
		if (re) begin
			rd_row_q <= row_mem_q[rd_addr];
		end
	end

	// hold the item's page and set
	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= in_page;
			set_q  <= in_set;
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			cpu_q        <= '0;
			cnt_q        <= '0;
			victim_q     <= '0;
			scan_q       <= '0;
			use_clock_q  <= '0;
			res_status_q <= mltlb_pkg::STATUS_DONE;
			res_hit_q    <= 1'b0;
			res_way_q    <= '0;
			res_count_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= mltlb_pkg::STATUS_DONE;
		end else begin
			// drain the output register
			if (state_q == ST_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {2'b00, res_count_q, mltlb_pkg::WAY_O_W'(res_way_q), res_hit_q};
				m_tuser_q  <= res_status_q;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ROW_AW'(1);
					if (clr_q == ROW_AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						res_status_q <= mltlb_pkg::STATUS_DONE;
						res_hit_q    <= 1'b0;
						res_way_q    <= '0;
						res_count_q  <= '0;
						cnt_q        <= '0;
						if (in_op == mltlb_pkg::OP_INVAL) begin
							cpu_q   <= '0;
							state_q <= (cpus_eff != '0) ? ST_INV_LOOK : ST_FIN;
						end else if ({1'b0, in_cpu} < cpus_eff) begin
							cpu_q   <= {1'b0, in_cpu};
							state_q <= ST_ACC_LOOK;
						end else begin
							res_status_q <= mltlb_pkg::STATUS_BAD_CPU;
							state_q      <= ST_FIN;
						end
					end
				end
				ST_ACC_LOOK: begin
					if (acc_we) begin
						res_hit_q   <= hit_any;
						res_way_q   <= acc_way;
						use_clock_q <= use_clock_q + mltlb_pkg::STAMP_W'(1);
						state_q     <= ST_FIN;
					end else begin
						victim_q <= '0;
						scan_q   <= WAY_W'(1);
						state_q  <= ST_ACC_SCAN;
					end
				end
				ST_ACC_SCAN: begin
					if (last_scan) begin
						res_way_q   <= v_next;
						use_clock_q <= use_clock_q + mltlb_pkg::STAMP_W'(1);
						state_q     <= ST_FIN;
					end else begin
						victim_q <= v_next;
						scan_q   <= scan_q + WAY_W'(1);
					end
				end
				ST_INV_LOOK: begin
					cnt_q <= cnt_q + mltlb_pkg::COUNT_W'(hit_any);
					if (inv_more) begin
						cpu_q <= cpu_next;
					end else begin
						res_count_q <= cnt_q + mltlb_pkg::COUNT_W'(hit_any);
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/mltlb_checker.sv -----
`default_nettype none

module mltlb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata,
	input wire logic [0:0]  m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// a flagged CPU leaves every result field zero
	a_bad_cpu: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == mltlb_pkg::STATUS_BAD_CPU) |-> m_tdata == 8'h00)
		else $error("flagged result carries data");

	// a clear count only comes from an invalidate, which reports no hit or way
	a_inval_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[5:3] != 3'd0) |-> m_tdata[2:0] == 3'd0)
		else $error("invalidate result carries hit or way");

endmodule

bind multi_cpu_lru_tlb_with_shootdown_unit mltlb_checker u_mltlb_checker (.*);

`default_nettype wire
